@@ rtl/core/pqadc_pkg.sv @@
// Shared types, constants and saturating-step functions for the PQ ADC distance accumulator.
package pqadc_pkg;

  localparam int KSUB         = 256;
  localparam int MAX_SUBQ_DEF = 64;
  localparam int LANES        = 4;
  localparam int IDX_W        = 14;
  localparam int VAL_W        = 32;
  localparam int CB_W         = 7;
  localparam int SUM_W        = 35;
  localparam int IN_TDATA_W   = 80;
  localparam int IDX_LSB      = 0;
  localparam int VAL_LSB      = IDX_LSB + IDX_W;
  localparam int CODE_LSB     = VAL_LSB + VAL_W;

  localparam logic [CB_W-1:0]         CB_RESET = CB_W'(16);
  localparam logic signed [VAL_W-1:0] VAL_MAX  = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN  = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum logic {
    FUNC_WRITE = 1'b0,
    FUNC_CODE  = 1'b1
  } func_t;

  // Composite of saturating adds: x -> clamp(x + acc, lo, hi); mx/mn are the
  // extreme prefix sums, used to tell whether any step clamped.
  typedef struct packed {
    logic signed [SUM_W-1:0] acc;
    logic signed [VAL_W-1:0] lo;
    logic signed [VAL_W-1:0] hi;
    logic signed [SUM_W-1:0] mx;
    logic signed [SUM_W-1:0] mn;
  } step_t;

  typedef struct packed {
    logic valid;
    logic last;
  } pipe_ctl_t;

  function automatic int grp_width(input int grp);
    int w;
    w = $clog2(grp);
    if (w < 1) begin
      w = 1;
    end
    return w;
  endfunction

  function automatic logic signed [VAL_W-1:0] sat_clamp(
    input logic signed [SUM_W-1:0] v,
    input logic signed [VAL_W-1:0] lo,
    input logic signed [VAL_W-1:0] hi
  );
    logic signed [SUM_W-1:0] lo_x;
    logic signed [SUM_W-1:0] hi_x;
    lo_x = SUM_W'(lo);
    hi_x = SUM_W'(hi);
    if (v < lo_x) begin
      return lo;
    end else if (v > hi_x) begin
      return hi;
    end
    return v[VAL_W-1:0];
  endfunction

  function automatic step_t base_step(input logic signed [VAL_W-1:0] v);
    step_t s;
    s.acc = SUM_W'(v);
    s.lo  = VAL_MIN;
    s.hi  = VAL_MAX;
    s.mx  = SUM_W'(v);
    s.mn  = SUM_W'(v);
    return s;
  endfunction

  // f1 applied first, then f2
  function automatic step_t compose(input step_t f1, input step_t f2);
    step_t r;
    logic signed [SUM_W-1:0] sh_mx;
    logic signed [SUM_W-1:0] sh_mn;
    r.acc = f1.acc + f2.acc;
    r.lo  = sat_clamp(SUM_W'(f1.lo) + f2.acc, f2.lo, f2.hi);
    r.hi  = sat_clamp(SUM_W'(f1.hi) + f2.acc, f2.lo, f2.hi);
    sh_mx = f1.acc + f2.mx;
    sh_mn = f1.acc + f2.mn;
    r.mx  = (f1.mx > sh_mx) ? f1.mx : sh_mx;
    r.mn  = (f1.mn < sh_mn) ? f1.mn : sh_mn;
    return r;
  endfunction

endpackage

@@ rtl/core/pq_adc_distance_accumulator_unit.sv @@
// Top level of the PQ asymmetric distance accumulator with four table lanes.
//
// Input stream (in_*): in_tuser = 0 writes entry_value into table entry
// entry_index; in_tuser = 1 carries four code bytes, lowest byte first.
// One transaction is accepted per cycle while in_tready is high, writes and code words alike.
// Table entries sit in four banks by subquantizer modulo four, so all four
// bytes of a code word are looked up in the same cycle.
// Config (cfg_*): code_bytes, always ready; write it only while idle.
// Output stream (out_*): one transaction per finished code, distance in
// out_tdata, clamp flag in out_tuser.
// Result path: lane read registers, merge pair registers, merged step
// register, then the output register that drives out_tvalid.
// Throughput: one input transaction per cycle while in_tready is high; the
// accumulator folds one pre-merged word per cycle unless stalled.
// Stall: the output register holds one result; while it waits, partial
// code words keep flowing and in_tready drops only when a finished code
// reaches the accumulator with the register still full.
// Reset: synchronous, active low; sum, position, flag and valid clear,
// code_bytes returns to 16. Table contents are undefined until written.
module pq_adc_distance_accumulator_unit import pqadc_pkg::*; #(
  parameter int MAX_SUBQ = MAX_SUBQ_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,   // entry_index, entry_value, code_word, zero pad
  input  logic                  in_tuser,   // func
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [VAL_W-1:0]      out_tdata,  // distance
  output logic                  out_tuser,  // saturated
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CB_W-1:0]       cfg_data
);

  localparam int MAXG      = MAX_SUBQ / 4;
  localparam int GRP       = (MAX_SUBQ + 3) / 4;
  localparam int GW        = grp_width(GRP);
  localparam int GCW       = $clog2(MAXG + 1);
  localparam int TBL_DEPTH = MAX_SUBQ * KSUB;
  localparam logic [4:0] MAXG5 = 5'(MAXG);

  logic [CB_W-1:0]         code_bytes_r;
  logic [GCW-1:0]          grp_r;
  logic [GCW-1:0]          grp_nxt;
  logic [GCW-1:0]          grp_inc;
  logic [GCW-1:0]          len_grp;
  logic [4:0]              len5;
  logic [4:0]              cb_grp;
  logic                    acc_in;
  logic                    acc_code;
  logic                    acc_write;
  logic                    wr_ok;
  logic                    last;
  logic                    adv;
  logic                    stall;
  logic [IDX_W-1:0]        in_idx;
  logic signed [VAL_W-1:0] in_val;
  logic [VAL_W-1:0]        in_code;
  logic [3:0]              wr_grp4;
  logic [GW+7:0]           wr_addr;
  logic signed [VAL_W-1:0] lane_val [LANES];
  pipe_ctl_t               s1_ctl_r;
  pipe_ctl_t               s1_ctl_nxt;
  pipe_ctl_t               s3_ctl;
  step_t                   s3_step;

  assign adv       = ~stall;
  assign in_tready = adv;
  assign cfg_ready = 1'b1;

  assign in_idx  = in_tdata[IDX_LSB +: IDX_W];
  assign in_val  = in_tdata[VAL_LSB +: VAL_W];
  assign in_code = in_tdata[CODE_LSB +: VAL_W];

  assign acc_in    = in_tvalid & adv;
  assign acc_code  = acc_in & (func_t'(in_tuser) == FUNC_CODE);
  assign acc_write = acc_in & (func_t'(in_tuser) == FUNC_WRITE);
  assign wr_ok     = acc_write & ({1'b0, in_idx} < (IDX_W + 1)'(TBL_DEPTH));
  assign wr_grp4   = in_idx[IDX_W-1:10];
  assign wr_addr   = {wr_grp4[GW-1:0], in_idx[7:0]};

  always_comb begin
    cb_grp = code_bytes_r[CB_W-1:2];
    if (cb_grp == 5'd0) begin
      len5 = 5'd1;
    end else if (cb_grp > MAXG5) begin
      len5 = MAXG5;
    end else begin
      len5 = cb_grp;
    end
    len_grp    = len5[GCW-1:0];
    grp_inc    = GCW'(grp_r + 1'b1);
    last       = (grp_inc >= len_grp);
    grp_nxt    = last ? '0 : grp_inc;
    s1_ctl_nxt.valid = acc_code;
    s1_ctl_nxt.last  = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_bytes_r <= CB_RESET;
      grp_r        <= '0;
      s1_ctl_r     <= '0;
    end else begin
      if (cfg_valid) begin
        code_bytes_r <= cfg_data;
      end
      if (acc_code) begin
        grp_r <= grp_nxt;
      end
      if (adv) begin
        s1_ctl_r <= s1_ctl_nxt;
      end
    end
  end

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    pqadc_lane #(
      .GRP (GRP)
    ) u_lane (
      .clk     (clk),
      .wr_en   (wr_ok & (in_idx[9:8] == 2'(k))),
      .wr_addr (wr_addr),
      .wr_data (in_val),
      .rd_en   (acc_code),
      .rd_addr ({grp_r[GW-1:0], in_code[8*k +: 8]}),
      .rd_data (lane_val[k])
    );
  end

  pqadc_merge u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_ctl   (s1_ctl_r),
    .lane_val (lane_val),
    .out_ctl  (s3_ctl),
    .out_step (s3_step)
  );

  pqadc_accum u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .s3_ctl     (s3_ctl),
    .s3_step    (s3_step),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .stall      (stall)
  );

  a_stall_needs_full_out: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without a waiting result");

  a_grp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    grp_r < GCW'(MAXG))
    else $error("code position beyond maximum length");

  a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s3_ctl.valid && s3_ctl.last) |=> out_tvalid)
    else $error("finished code did not produce a result");

  a_stall_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    stall |-> (s3_ctl.valid && s3_ctl.last))
    else $error("pipeline held without a finished code");

endmodule

@@ rtl/core/pqadc_lane.sv @@
// One lookup table bank: subquantizers congruent to the lane number modulo four.
module pqadc_lane import pqadc_pkg::*; #(
  parameter int GRP = (MAX_SUBQ_DEF + 3) / 4
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [grp_width(GRP)+7:0] wr_addr,
  input  logic signed [VAL_W-1:0]  wr_data,
  input  logic                     rd_en,
  input  logic [grp_width(GRP)+7:0] rd_addr,
  output logic signed [VAL_W-1:0]  rd_data
);

  localparam int DEPTH = GRP * KSUB;

  logic signed [VAL_W-1:0] mem [DEPTH];
  logic signed [VAL_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/core/pqadc_merge.sv @@
// Two-level registered tree that composes the four lane steps of one code word.
module pqadc_merge import pqadc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  pipe_ctl_t               in_ctl,
  input  logic signed [VAL_W-1:0] lane_val [LANES],
  output pipe_ctl_t               out_ctl,
  output step_t                   out_step
);

  step_t     pair0_r;
  step_t     pair1_r;
  step_t     pair0_nxt;
  step_t     pair1_nxt;
  step_t     step_r;
  step_t     step_nxt;
  pipe_ctl_t ctl_a_r;
  pipe_ctl_t ctl_b_r;

  always_comb begin
    pair0_nxt = compose(base_step(lane_val[0]), base_step(lane_val[1]));
    pair1_nxt = compose(base_step(lane_val[2]), base_step(lane_val[3]));
    step_nxt  = compose(pair0_r, pair1_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r <= '0;
      ctl_b_r <= '0;
    end else if (adv) begin
      ctl_a_r <= in_ctl;
      ctl_b_r <= ctl_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pair0_r <= pair0_nxt;
      pair1_r <= pair1_nxt;
      step_r  <= step_nxt;
    end
  end

  assign out_ctl  = ctl_b_r;
  assign out_step = step_r;

endmodule

@@ rtl/core/pqadc_accum.sv @@
// Saturating running sum, clamp flag and the result output register.
module pqadc_accum import pqadc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  pipe_ctl_t               s3_ctl,
  input  step_t                   s3_step,
  input  logic                    out_tready,
  output logic                    out_tvalid,
  output logic [VAL_W-1:0]        out_tdata,
  output logic                    out_tuser,
  output logic                    stall
);

  logic signed [VAL_W-1:0] sum_r;
  logic signed [VAL_W-1:0] sum_nxt;
  logic                    clamp_r;
  logic                    clamp_nxt;
  logic                    out_valid_r;
  logic                    out_valid_nxt;
  logic [VAL_W-1:0]        out_data_r;
  logic                    out_sat_r;
  logic signed [SUM_W-1:0] s_ext;
  logic signed [SUM_W-1:0] peak_hi;
  logic signed [SUM_W-1:0] peak_lo;
  logic                    take;
  logic                    emit;
  logic                    hit;

  assign stall = s3_ctl.valid & s3_ctl.last & out_valid_r & ~out_tready;
  assign take  = s3_ctl.valid & ~stall;
  assign emit  = take & s3_ctl.last;

  always_comb begin
    s_ext     = SUM_W'(sum_r);
    peak_hi   = s_ext + s3_step.mx;
    peak_lo   = s_ext + s3_step.mn;
    hit       = (peak_hi > SUM_W'(VAL_MAX)) | (peak_lo < SUM_W'(VAL_MIN));
    sum_nxt   = sat_clamp(s_ext + s3_step.acc, s3_step.lo, s3_step.hi);
    clamp_nxt = clamp_r | hit;
    out_valid_nxt = (out_valid_r & ~out_tready) | emit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      clamp_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        if (s3_ctl.last) begin
          sum_r   <= '0;
          clamp_r <= 1'b0;
        end else begin
          sum_r   <= sum_nxt;
          clamp_r <= clamp_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= sum_nxt;
      out_sat_r  <= clamp_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sat_r;

endmodule
